### design/csu_pkg.sv
// Package for the counting semaphore unit: sizes, status and action codes,
// sequencer states and the structs that pass between the core and the wait table.
// No dependencies.
package csu_pkg;

    localparam int NUM_THREADS = 8;
    localparam int NUM_SEMS    = 8;
    localparam int COUNT_BITS  = 8;

    // Widths of the request and response fields.
    localparam int ACTION_W    = 1;
    localparam int SEM_ID_W    = 3;
    localparam int THR_ID_W    = 3;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 8;

    // Index widths derived from the table sizes.
    localparam int THR_IDX_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int SEM_IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [THR_IDX_W-1:0]  THR_LAST  = THR_IDX_W'(NUM_THREADS - 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_TAKE    = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED   = 3'd0,
        STAT_BLOCKED   = 3'd1,
        STAT_REL_IDLE  = 3'd2,
        STAT_REL_WOKE  = 3'd3,
        STAT_ERROR     = 3'd4,
        STAT_SATURATED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_SCAN,
        SEQ_OUT
    } seq_state_t;

    // Command from the core to the wait table; one address serves both read and update.
    typedef struct packed {
        logic                 set_blk;
        logic                 clr_blk;
        logic [THR_IDX_W-1:0] addr;
        logic [SEM_ID_W-1:0]  sem;
    } wq_cmd_t;

    // Entry of the wait table at the commanded address.
    typedef struct packed {
        logic                blocked;
        logic [SEM_ID_W-1:0] wait_sem;
    } wq_stat_t;

    // Count reported on the response, clipped to the field width.
    function automatic logic [COUNT_OUT_W-1:0] clip_count(input logic [COUNT_BITS-1:0] c);
        logic [16:0] wide;
        wide = 17'(c);
        if (wide > 17'd255)
        begin
            return {COUNT_OUT_W{1'b1}};
        end
        return COUNT_OUT_W'(c);
    endfunction

endpackage

### design/csu_req_if.sv
// Request channel of the counting semaphore unit: valid/ready plus the request fields.
// Depends on csu_pkg.
interface csu_req_if
    import csu_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SEM_ID_W-1:0] sem_id;
    logic [THR_ID_W-1:0] thread_id;

    modport source (output valid, output action, output sem_id, output thread_id, input ready);
    modport sink   (input valid, input action, input sem_id, input thread_id, output ready);
endinterface

### design/csu_rsp_if.sv
// Response channel of the counting semaphore unit: valid/ready plus the result fields.
// Depends on csu_pkg.
interface csu_rsp_if
    import csu_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [THR_ID_W-1:0]    woken_thread;
    logic [COUNT_OUT_W-1:0] count_after;

    modport source (output valid, output status, output woken_thread, output count_after,
                    input ready);
    modport sink   (input valid, input status, input woken_thread, input count_after,
                    output ready);
endinterface

### design/counting_semaphore_unit_core.sv
// Counting semaphore unit with a per-thread wait list; top level.
// A take passes through the EXEC and OUT states to the response register; a release also
// walks the wait table in SCAN, one thread entry per cycle through a single compare. A new
// request is taken only in IDLE, and OUT holds until the response register can load.
// Reset (rst_n, asynchronous, active low) clears all counts, all blocked flags and the
// sequencer at once; no clearing pass is needed.
// Depends on csu_pkg, csu_req_if, csu_rsp_if and csu_wait_table.
module counting_semaphore_unit_core
    import csu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    csu_req_if.sink   req,
    csu_rsp_if.source rsp
);

    // Sequencer and captured request.
    seq_state_t             state_reg, state_next;
    logic [ACTION_W-1:0]    act_reg;
    logic [SEM_ID_W-1:0]    sem_reg;
    logic [THR_ID_W-1:0]    thr_reg;
    logic [THR_IDX_W-1:0]   scan_reg, scan_next;

    // Semaphore counts. Read at the captured semaphore only.
    logic [COUNT_BITS-1:0]  sem_count_reg [NUM_SEMS];
    logic                   cnt_we;
    logic [COUNT_BITS-1:0]  cnt_wdata;

    // Result held between the decision and the response register.
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [THR_ID_W-1:0]    res_woken_reg, res_woken_next;
    logic [COUNT_OUT_W-1:0] res_count_reg, res_count_next;

    // Response register; it parts the response side from the sequencer.
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [THR_ID_W-1:0]    out_woken_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    wq_cmd_t                wq_cmd;
    wq_stat_t               wq_stat;

    logic                   req_fire;
    logic                   out_load;
    logic                   sem_ok;
    logic                   thr_ok;
    logic [SEM_IDX_W-1:0]   sem_idx;
    logic [COUNT_BITS-1:0]  cnt_cur;
    logic                   scan_hit;
    logic                   scan_last;

    csu_wait_table u_wait_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (wq_cmd),
        .stat  (wq_stat)
    );

    // The block takes a request only when the sequencer is idle; a response may still
    // be waiting in the response register at that time.
    assign req.ready = (state_reg == SEQ_IDLE);
    assign req_fire  = req.valid && req.ready;

    // The result moves into the response register when that register is empty or its
    // beat is being taken in this cycle.
    assign out_load = (state_reg == SEQ_OUT) && (!out_valid_reg || rsp.ready);

    // Range checks are done at a width of seven bits, which holds table sizes up to 127.
    assign sem_ok  = (7'(sem_reg) < 7'(NUM_SEMS));
    assign thr_ok  = (7'(thr_reg) < 7'(NUM_THREADS));
    assign sem_idx = SEM_IDX_W'(sem_reg);
    assign cnt_cur = sem_count_reg[sem_idx];

    // The shared compare of the scan: is the thread at the scan address waiting on
    // the requested semaphore?
    assign scan_hit  = wq_stat.blocked && (wq_stat.wait_sem == sem_reg);
    assign scan_last = (scan_reg == THR_LAST);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC:
            begin
                // A valid release walks the wait table; everything else is decided now.
                if (sem_ok && (act_reg == ACT_RELEASE))
                begin
                    state_next = SEQ_SCAN;
                    scan_next  = '0;
                end
                else
                begin
                    state_next = SEQ_OUT;
                end
            end
            SEQ_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = SEQ_OUT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            SEQ_OUT:
            begin
                if (out_load)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Datapath control and result of the sequencer.
    always_comb
    begin
        wq_cmd          = '0;
        wq_cmd.sem      = sem_reg;
        wq_cmd.addr     = THR_IDX_W'(thr_reg);
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_cur;
        res_status_next = res_status_reg;
        res_woken_next  = res_woken_reg;
        res_count_next  = res_count_reg;
        case (state_reg)
            SEQ_EXEC:
            begin
                res_woken_next = '0;
                if (!sem_ok)
                begin
                    res_status_next = STAT_ERROR;
                    res_count_next  = '0;
                end
                else if (act_reg == ACT_TAKE)
                begin
                    res_count_next = clip_count(cnt_cur);
                    if (!thr_ok || wq_stat.blocked)
                    begin
                        // A thread already waiting cannot take again.
                        res_status_next = STAT_ERROR;
                    end
                    else if (cnt_cur != '0)
                    begin
                        cnt_we          = 1'b1;
                        cnt_wdata       = cnt_cur - 1'b1;
                        res_status_next = STAT_GRANTED;
                        res_count_next  = clip_count(cnt_cur - 1'b1);
                    end
                    else
                    begin
                        wq_cmd.set_blk  = 1'b1;
                        res_status_next = STAT_BLOCKED;
                    end
                end
            end
            SEQ_SCAN:
            begin
                wq_cmd.addr    = scan_reg;
                res_count_next = clip_count(cnt_cur);
                if (scan_hit)
                begin
                    // The unit goes straight to the lowest waiting thread; the count holds.
                    wq_cmd.clr_blk  = 1'b1;
                    res_status_next = STAT_REL_WOKE;
                    res_woken_next  = THR_ID_W'(scan_reg);
                end
                else if (scan_last)
                begin
                    if (cnt_cur == COUNT_MAX)
                    begin
                        res_status_next = STAT_SATURATED;
                    end
                    else
                    begin
                        cnt_we          = 1'b1;
                        cnt_wdata       = cnt_cur + 1'b1;
                        res_status_next = STAT_REL_IDLE;
                        res_count_next  = clip_count(cnt_cur + 1'b1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                sem_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            if (cnt_we)
            begin
                sem_count_reg[sem_idx] <= cnt_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            act_reg <= req.action;
            sem_reg <= req.sem_id;
            thr_reg <= req.thread_id;
        end
        res_status_reg <= res_status_next;
        res_woken_reg  <= res_woken_next;
        res_count_reg  <= res_count_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_woken_reg  <= res_woken_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.woken_thread = out_woken_reg;
    assign rsp.count_after  = out_count_reg;

endmodule

### design/csu_wait_table.sv
// Per-thread wait table: blocked flag and waited semaphore for each thread.
// Depends on csu_pkg.
module csu_wait_table
    import csu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  wq_cmd_t  cmd,
    output wq_stat_t stat
);

    logic [NUM_THREADS-1:0] blocked_reg;
    logic [SEM_ID_W-1:0]    wait_sem_reg [NUM_THREADS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocked_reg <= '0;
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                wait_sem_reg[i] <= '0;
            end
        end
        else if (cmd.set_blk)
        begin
            blocked_reg[cmd.addr]  <= 1'b1;
            wait_sem_reg[cmd.addr] <= cmd.sem;
        end
        else if (cmd.clr_blk)
        begin
            blocked_reg[cmd.addr]  <= 1'b0;
            wait_sem_reg[cmd.addr] <= '0;
        end
    end

    assign stat.blocked  = blocked_reg[cmd.addr];
    assign stat.wait_sem = wait_sem_reg[cmd.addr];

endmodule

### tb/csu_response_checker.sv
// Checker for the counting semaphore unit: keeps its own copy of the semaphore
// counts and the wait list, predicts each response beat and compares it.
// Depends on csu_pkg, csu_req_if and csu_rsp_if.
module csu_response_checker
    import csu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    csu_req_if   req,
    csu_rsp_if   rsp,
    output int   fail_count,
    output int   results_due,
    output int   beats_checked,
    output int   woke_beats,
    output int   saturated_beats,
    output int   error_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t                status;
        logic [THR_ID_W-1:0]    woken;
        logic [COUNT_OUT_W-1:0] count;
    } sem_result_t;

    logic [COUNT_BITS-1:0] sem_level   [NUM_SEMS];
    logic                  thr_waiting [NUM_THREADS];
    logic [SEM_ID_W-1:0]   thr_wait_on [NUM_THREADS];
    sem_result_t           predicted_results [$];
    sem_result_t           oldest;

    // Applies one request to the local copy of the state and returns the response.
    function automatic sem_result_t apply_request(input logic [ACTION_W-1:0] act,
                                                  input logic [SEM_ID_W-1:0] sem,
                                                  input logic [THR_ID_W-1:0] thr);
        sem_result_t r;
        int          k;
        int          waker;
        r.status = STAT_ERROR;
        r.woken  = '0;
        r.count  = '0;
        waker    = -1;
        if (int'(sem) >= NUM_SEMS)
        begin
            return r;
        end
        if (act == ACT_TAKE)
        begin
            if (int'(thr) >= NUM_THREADS || thr_waiting[thr])
            begin
                r.status = STAT_ERROR;
            end
            else if (sem_level[sem] != '0)
            begin
                sem_level[sem] = sem_level[sem] - 1'b1;
                r.status = STAT_GRANTED;
            end
            else
            begin
                thr_waiting[thr] = 1'b1;
                thr_wait_on[thr] = sem;
                r.status = STAT_BLOCKED;
            end
        end
        else
        begin
            // Scan downward so the lowest-numbered waiter is the one kept.
            for (k = NUM_THREADS - 1; k >= 0; k--)
            begin
                if (thr_waiting[k] && thr_wait_on[k] == sem)
                begin
                    waker = k;
                end
            end
            if (waker >= 0)
            begin
                thr_waiting[waker] = 1'b0;
                thr_wait_on[waker] = '0;
                r.woken  = THR_ID_W'(waker);
                r.status = STAT_REL_WOKE;
            end
            else if (sem_level[sem] == COUNT_MAX)
            begin
                r.status = STAT_SATURATED;
            end
            else
            begin
                sem_level[sem] = sem_level[sem] + 1'b1;
                r.status = STAT_REL_IDLE;
            end
        end
        r.count = (int'(sem_level[sem]) > 255) ? '1 : COUNT_OUT_W'(sem_level[sem]);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("csu_response_checker: %0t ns: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SEMS; k++)
            begin
                sem_level[k] = '0;
            end
            for (int k = 0; k < NUM_THREADS; k++)
            begin
                thr_waiting[k] = 1'b0;
                thr_wait_on[k] = '0;
            end
            predicted_results.delete();
            fail_count      = 0;
            results_due     = 0;
            beats_checked   = 0;
            woke_beats      = 0;
            saturated_beats = 0;
            error_beats     = 0;
        end
        else
        begin
            // The response side is checked first so that a beat leaving in the same
            // cycle as a new request is matched against the older expectation.
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    report_mismatch($sformatf("response beat with nothing outstanding, status %0d",
                                              rsp.status));
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    if (rsp.status !== oldest.status)
                    begin
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  rsp.status, oldest.status.name()));
                    end
                    if (rsp.woken_thread !== oldest.woken)
                    begin
                        report_mismatch($sformatf("woken_thread %0d, expected %0d",
                                                  rsp.woken_thread, oldest.woken));
                    end
                    if (rsp.count_after !== oldest.count)
                    begin
                        report_mismatch($sformatf("count_after %0d, expected %0d",
                                                  rsp.count_after, oldest.count));
                    end
                    beats_checked++;
                    if (oldest.status == STAT_REL_WOKE)
                    begin
                        woke_beats++;
                    end
                    if (oldest.status == STAT_SATURATED)
                    begin
                        saturated_beats++;
                    end
                    if (oldest.status == STAT_ERROR)
                    begin
                        error_beats++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                predicted_results.push_back(apply_request(req.action, req.sem_id,
                                                          req.thread_id));
            end
            results_due = predicted_results.size();
        end
    end

endmodule

### tb/counting_semaphore_unit_core_tb.sv
// Testbench top for the counting semaphore unit: clock, reset, request stimulus,
// response back-pressure and the verdict.
// Depends on csu_pkg, csu_req_if, csu_rsp_if, csu_response_checker and the core.
module counting_semaphore_unit_core_tb
    import csu_pkg::*;
    ;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of random request beats after the directed part.
    localparam int RANDOM_ITEMS = 1700;
    // Cycles to wait at the end, to cover the longest release sequence with room to spare.
    localparam int DRAIN_CYCLES = 4 * (NUM_THREADS + 3);
    // Responses are refused for this many cycles once, to back the block up.
    localparam int HOLD_CYCLES  = 300;

    logic clk = 1'b0;
    logic rst_n;

    csu_req_if req ();
    csu_rsp_if rsp ();

    int  fail_count;
    int  results_due;
    int  beats_checked;
    int  woke_beats;
    int  saturated_beats;
    int  error_beats;
    int  n_sent;
    int  n_accepted;
    logic rsp_hold;
    logic quiet;

    counting_semaphore_unit_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    csu_response_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .results_due     (results_due),
        .beats_checked   (beats_checked),
        .woke_beats      (woke_beats),
        .saturated_beats (saturated_beats),
        .error_beats     (error_beats)
    );

    always #5 clk = ~clk;

    // Accepted request beats are counted at the rising edge; the count is only read
    // at falling edges, so the stimulus never races with it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_accepted = 0;
        end
        else if (req.valid && req.ready)
        begin
            n_accepted++;
        end
    end

    // A window of accepted beats in which neither side idles, so the block also sees
    // back-to-back traffic.
    assign quiet = (n_accepted >= 300) && (n_accepted < 650);

    // Response side: ready drops about 15 times in a hundred, never during the quiet
    // window, and stays low during the long hold below.
    always @(negedge clk)
    begin
        if (rsp_hold)
        begin
            rsp.ready <= 1'b0;
        end
        else if (quiet)
        begin
            rsp.ready <= 1'b1;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= 15);
        end
    end

    // Long hold on the response side. The sender keeps offering requests meanwhile,
    // so the block fills up and has to lower its request ready.
    initial
    begin
        rsp_hold = 1'b0;
        wait (n_accepted >= 900);
        @(posedge clk);
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    // Offers one request beat. Called at a falling edge and returns at the falling
    // edge after the beat was taken, with valid still high, so that the next call
    // either keeps it high or idles; valid is assigned only once per edge.
    task automatic send_request(input action_t act, input logic [SEM_ID_W-1:0] sem,
                                input logic [THR_ID_W-1:0] thr);
        while (!quiet && $urandom_range(99) < 15)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.action    <= act;
        req.sem_id    <= sem;
        req.thread_id <= thr;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        n_sent++;
        @(negedge clk);
    endtask

    function automatic logic [SEM_ID_W-1:0] any_sem();
        return SEM_ID_W'($urandom_range((1 << SEM_ID_W) - 1));
    endfunction

    function automatic logic [THR_ID_W-1:0] any_thread();
        return THR_ID_W'($urandom_range((1 << THR_ID_W) - 1));
    endfunction

    function automatic action_t any_action(input int release_pct);
        return ($urandom_range(99) < release_pct) ? ACT_RELEASE : ACT_TAKE;
    endfunction

    // Safety net: a run that hangs on a handshake ends here.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [SEM_ID_W-1:0] base_sem;
        logic [SEM_ID_W-1:0] sem;
        int                  run_len;
        int                  pick;
        bit                  burst_done;

        req.valid     = 1'b0;
        req.action    = ACT_TAKE;
        req.sem_id    = '0;
        req.thread_id = '0;
        rsp.ready     = 1'b0;
        rst_n         = 1'b0;
        n_sent        = 0;
        burst_done    = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. All counts start at zero, so the first take blocks. A
        // blocked thread that takes again is refused. Releases wake the waiters one
        // by one before the count moves, and the thread field of a release is junk.
        send_request(ACT_TAKE,    3'd0, 3'd0);
        send_request(ACT_TAKE,    3'd0, 3'd0);
        send_request(ACT_TAKE,    3'd0, 3'd7);
        send_request(ACT_RELEASE, 3'd0, 3'd5);
        send_request(ACT_RELEASE, 3'd0, 3'd0);
        send_request(ACT_RELEASE, 3'd0, 3'd7);
        send_request(ACT_TAKE,    3'd0, 3'd3);
        // Three waiters on the top semaphore, queued out of order: the lowest thread
        // number must come out first, whatever the order of blocking.
        send_request(ACT_TAKE,    3'd7, 3'd5);
        send_request(ACT_TAKE,    3'd7, 3'd2);
        send_request(ACT_TAKE,    3'd7, 3'd6);
        send_request(ACT_RELEASE, 3'd7, 3'd7);
        send_request(ACT_RELEASE, 3'd7, 3'd0);
        send_request(ACT_RELEASE, 3'd7, 3'd3);
        send_request(ACT_RELEASE, 3'd7, 3'd1);
        send_request(ACT_RELEASE, 3'd7, 3'd4);
        send_request(ACT_TAKE,    3'd7, 3'd7);
        // A thread blocked on one semaphore is refused on another, and a release of
        // that other one must not wake it.
        send_request(ACT_TAKE,    3'd3, 3'd4);
        send_request(ACT_TAKE,    3'd5, 3'd4);
        send_request(ACT_RELEASE, 3'd5, 3'd2);
        send_request(ACT_RELEASE, 3'd3, 3'd6);
        send_request(ACT_TAKE,    3'd5, 3'd4);

        // Random part. Most traffic stays on a pair of neighboring semaphores so that
        // takes and releases meet, threads pile up on the wait list and get woken.
        // Once, a long burst of releases drives one count to its maximum.
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS)
        begin
            if (!burst_done && n_sent >= 700)
            begin
                sem = any_sem();
                for (int i = 0; i < 270; i++)
                begin
                    send_request(ACT_RELEASE, sem, any_thread());
                end
                for (int i = 0; i < 20; i++)
                begin
                    send_request(ACT_TAKE, sem, any_thread());
                end
                for (int i = 0; i < 30; i++)
                begin
                    send_request(ACT_RELEASE, sem, any_thread());
                end
                burst_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                begin
                    base_sem = any_sem();
                    run_len  = $urandom_range(60, 20);
                    for (int i = 0; i < run_len; i++)
                    begin
                        sem = ($urandom_range(99) < 70) ? base_sem : base_sem + 1'b1;
                        send_request(any_action(55), sem, any_thread());
                    end
                end
                else
                begin
                    for (int i = 0; i < 10; i++)
                    begin
                        send_request(any_action(50), any_sem(), any_thread());
                    end
                end
            end
        end
        req.valid <= 1'b0;

        // Every response must come back, then nothing more may follow.
        wait (results_due == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d request beats after reset, %0d response beats compared.",
                 n_accepted, beats_checked);
        $display("Seen: %0d wakeups, %0d saturated releases, %0d refused requests.",
                 woke_beats, saturated_beats, error_beats);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
